// ===== rtl/bdnf_pkg.sv =====
// shared types, register indexes and event codes for the button debouncer
package bdnf_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int WIDE_BITS     = 64;
	localparam int NOW_BITS      = 32;
	localparam int DELAY_BITS    = 16;
	localparam int CFG_IDX_BITS  = 2;

	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
	typedef logic [1:0]              ev_code_t;

	localparam cfg_idx_t CFG_LOCKOUT     = 2'd0;
	localparam cfg_idx_t CFG_STABLE      = 2'd1;
	localparam cfg_idx_t CFG_ACTIVE_HIGH = 2'd2;

	localparam ev_code_t EV_RELEASED    = 2'd0;
	localparam ev_code_t EV_PRESSED     = 2'd1;
	localparam ev_code_t EV_TO_PRESSED  = 2'd2;
	localparam ev_code_t EV_TO_RELEASED = 2'd3;

	typedef struct packed {
		logic [DELAY_BITS-1:0] lockout_delay_ms;
		logic [DELAY_BITS-1:0] stable_delay_ms;
		logic                  active_high;
	} cfg_t;

endpackage

// ===== rtl/bdnf_cfg.sv =====
// configuration register file of the button debouncer
module bdnf_cfg import bdnf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  cfg_idx_t              cfg_index,
	input  logic [DELAY_BITS-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lockout_delay_ms <= '0;
			cfg_q.stable_delay_ms  <= '0;
			cfg_q.active_high      <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOCKOUT:     cfg_q.lockout_delay_ms <= cfg_data;
				CFG_STABLE:      cfg_q.stable_delay_ms  <= cfg_data;
				CFG_ACTIVE_HIGH: cfg_q.active_high      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/bdnf_filter.sv =====
// debounce state and per-sample decision logic
module bdnf_filter import bdnf_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 step,
	input  logic [TIME_BITS-1:0] now,
	input  logic                 level,
	output ev_code_t             ev
);

	logic                 stable_q;
	logic                 cand_q;
	logic                 init_q;
	logic [TIME_BITS-1:0] last_change_q;
	logic [TIME_BITS-1:0] cand_since_q;

	logic                 stable_cur;
	logic                 cand_cur;
	logic [WIDE_BITS-1:0] lockout_wide;
	logic [WIDE_BITS-1:0] stable_wide;
	logic [TIME_BITS-1:0] lockout_t;
	logic [TIME_BITS-1:0] stable_t;
	logic [TIME_BITS-1:0] el_lock;
	logic [TIME_BITS-1:0] el_cand;
	logic                 open;
	logic                 take_cand;
	logic                 accept;
	logic                 back_stable;

	assign stable_cur   = init_q ? stable_q : level;
	assign cand_cur     = init_q ? cand_q   : level;
	assign lockout_wide = {{(WIDE_BITS-DELAY_BITS){1'b0}}, cfg.lockout_delay_ms};
	assign stable_wide  = {{(WIDE_BITS-DELAY_BITS){1'b0}}, cfg.stable_delay_ms};
	assign lockout_t    = lockout_wide[TIME_BITS-1:0];
	assign stable_t     = stable_wide[TIME_BITS-1:0];
	assign el_lock      = now - last_change_q;
	assign el_cand      = now - cand_since_q;

	assign open        = (cfg.lockout_delay_ms == '0) || (el_lock > lockout_t);
	assign take_cand   = open && (level != stable_cur) &&
	                     (cfg.stable_delay_ms != '0) && (level != cand_cur);
	assign accept      = open && (level != stable_cur) && !take_cand &&
	                     (el_cand > stable_t);
	assign back_stable = open && (level == stable_cur);

	always_comb begin
		if (accept) begin
			ev = (level == cfg.active_high) ? EV_TO_PRESSED : EV_TO_RELEASED;
		end else begin
			ev = (stable_cur == cfg.active_high) ? EV_PRESSED : EV_RELEASED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q      <= 1'b0;
			cand_q        <= 1'b0;
			init_q        <= 1'b0;
			last_change_q <= '0;
			cand_since_q  <= '0;
		end else if (step) begin
			init_q   <= 1'b1;
			stable_q <= accept ? level : stable_cur;
			if (take_cand) begin
				cand_q       <= level;
				cand_since_q <= now;
			end else if (back_stable) begin
				cand_q <= stable_cur;
			end else begin
				cand_q <= cand_cur;
			end
			if (accept) begin
				last_change_q <= now;
			end
		end
	end

endmodule

// ===== rtl/button_debounce_noise_filter.sv =====
// top level of the button debouncer with noise filter and lockout
// One sample beat per clock while in_stall is low; a result beat follows its
// sample beat through the sample register, then the result register. The decision
// is combinational between the two registers and the state updates as the result
// register loads, so back-to-back samples see each other's effect. in_stall rises only while a result is
// held by out_stall and a further sample is already waiting.
module button_debounce_noise_filter import bdnf_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [NOW_BITS-1:0]   now_ms,
	input  logic                  raw_level,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            button_event,
	input  logic                  cfg_we,
	input  cfg_idx_t              cfg_index,
	input  logic [DELAY_BITS-1:0] cfg_data
);

	cfg_t                 cfg;
	logic                 valid_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic                 level_s1;
	logic                 valid_s2;
	ev_code_t             ev_s2;
	ev_code_t             ev;
	logic                 advance;
	logic                 fire;
	logic                 take_in;
	logic [WIDE_BITS-1:0] now_wide;

	assign advance  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign take_in  = in_valid && !in_stall;
	assign now_wide = {{(WIDE_BITS-NOW_BITS){1'b0}}, now_ms};

	bdnf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bdnf_filter #(
		.TIME_BITS (TIME_BITS)
	) u_filter (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (fire),
		.now    (now_s1),
		.level  (level_s1),
		.ev     (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			now_s1   <= now_wide[TIME_BITS-1:0];
			level_s1 <= raw_level;
		end
		if (fire) begin
			ev_s2 <= ev;
		end
	end

	assign out_valid    = valid_s2;
	assign button_event = ev_s2;

endmodule

// ===== rtl/bdnf_checker.sv =====
// port-level checks of the button debouncer, bound to the top level
module bdnf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] button_event
);

	// held result beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(button_event))
		else $error("result beat changed while stalled");

	// back-pressure only comes from a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("sample stalled with result side free");

	// every taken sample is followed by a valid result beat
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> ##1 out_valid)
		else $error("no result after taken sample");

endmodule

bind button_debounce_noise_filter bdnf_checker u_bdnf_checker (.*);
